[rtl/ipv4_lpm_pkg.sv]
// Shared types, codes and helpers for the IPv4 longest-prefix-match forwarding unit.
// Used by ipv4_lpm_ctrl, ipv4_lpm_dp and ipv4_forward_lpm_unit; no dependencies.
package ipv4_lpm_pkg;

  // default route table depth
  localparam int unsigned TABLE_DEPTH_DEF = 16;

  // operation codes on the input beat
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_HEADER = 2'd2;

  // longest prefix length a route may carry
  localparam logic [5:0] MAX_PREFIX_LEN = 6'd32;

  // result verdicts
  typedef enum logic [1:0] {
    VERDICT_LOCAL     = 2'd0,
    VERDICT_TTL_ERROR = 2'd1,
    VERDICT_NO_ROUTE  = 2'd2,
    VERDICT_FORWARD   = 2'd3
  } verdict_t;

  // one route table entry; prefix is stored already masked
  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  len;
    logic [31:0] hop;
  } route_entry_t;

  // controller to datapath
  typedef struct packed {
    logic clear_table;
    logic add_route;
    logic take_word;
    logic walk_init;
    logic walk_step;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_end;
    logic is_local;
    logic ttl_zero;
  } status_t;

  // network mask for a prefix length of 0 to 32
  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    return ~(32'hFFFF_FFFF >> len);
  endfunction

endpackage

[rtl/ipv4_lpm_dp.sv]
// Datapath: route table memory, header capture, checksum accumulation and
// the table walk compare. Depends on ipv4_lpm_pkg; driven by ipv4_lpm_ctrl.
module ipv4_lpm_dp #(
  parameter int unsigned TABLE_DEPTH = ipv4_lpm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ipv4_lpm_pkg::cmd_t     cmd,
  output ipv4_lpm_pkg::status_t  status,
  input  logic [31:0]            route_prefix,
  input  logic [5:0]             route_prefix_length,
  input  logic [31:0]            route_next_hop,
  input  logic [15:0]            header_word,
  input  logic                   local_address_we,
  input  logic [31:0]            local_address,
  output logic [1:0]             verdict,
  output logic [31:0]            next_hop,
  output logic [15:0]            new_checksum
);
  import ipv4_lpm_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  // route table and config
  route_entry_t      route_table [TABLE_DEPTH];
  logic [31:0]       own_address;
  logic [CNT_W-1:0]  route_count;

  // header state
  logic [20:0]       running_sum;
  logic [4:0]        word_index;
  logic [31:0]       captured_destination;
  logic [7:0]        captured_ttl;
  logic [3:0]        captured_ihl;

  // walk state
  logic [CNT_W-1:0]  walk_index;
  route_entry_t      rd_entry;
  logic              rd_valid;
  logic [5:0]        best_len;
  logic [31:0]       best_hop;
  logic              found;

  logic [3:0]        ihl_eff;
  logic              sum_en;
  logic [15:0]       add_val;
  logic [5:0]        len_clamped;
  logic              hit;
  logic [16:0]       fold1;
  logic [16:0]       fold2;
  logic [15:0]       csum;
  verdict_t          verdict_next;

  // header word handling: IHL of this beat counts on word 0
  always_comb begin
    ihl_eff = (word_index == 5'd0) ? header_word[11:8] : captured_ihl;
    sum_en  = (word_index < {ihl_eff, 1'b0}) && (word_index != 5'd5);
    if ((word_index == 5'd4) && (header_word >= 16'h0100)) begin
      add_val = header_word - 16'h0100;
    end else begin
      add_val = header_word;
    end
  end

  // route add: clamp length
  assign len_clamped = (route_prefix_length > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN
                                                               : route_prefix_length;

  // walk compare on the registered table read
  assign hit = rd_valid && (rd_entry.len > best_len) &&
               ((captured_destination & prefix_mask(rd_entry.len)) == rd_entry.prefix);

  // end-around carry fold, twice
  always_comb begin
    fold1 = {1'b0, running_sum[15:0]} + {12'b0, running_sum[20:16]};
    fold2 = {1'b0, fold1[15:0]} + {16'b0, fold1[16]};
    csum  = ~fold2[15:0];
  end

  // verdict priority: local, TTL, route
  always_comb begin
    priority if (status.is_local) begin
      verdict_next = VERDICT_LOCAL;
    end else if (status.ttl_zero) begin
      verdict_next = VERDICT_TTL_ERROR;
    end else if (found) begin
      verdict_next = VERDICT_FORWARD;
    end else begin
      verdict_next = VERDICT_NO_ROUTE;
    end
  end

  assign status.walk_end = (walk_index == route_count);
  assign status.is_local = (captured_destination == own_address);
  assign status.ttl_zero = (captured_ttl == 8'd0);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address          <= '0;
      route_count          <= '0;
      running_sum          <= '0;
      word_index           <= '0;
      captured_destination <= '0;
      captured_ttl         <= '0;
      captured_ihl         <= '0;
      walk_index           <= '0;
      rd_valid             <= 1'b0;
      best_len             <= '0;
      found                <= 1'b0;
    end else begin
      if (local_address_we) begin
        own_address <= local_address;
      end
      if (cmd.clear_table) begin
        route_count <= '0;
      end else if (cmd.add_route && (route_count < DEPTH_CNT)) begin
        route_count <= route_count + 1'b1;
      end
      if (cmd.take_word) begin
        if (word_index == 5'd0) captured_ihl <= header_word[11:8];
        if (word_index == 5'd4) captured_ttl <= header_word[15:8];
        if (word_index == 5'd8) captured_destination[31:16] <= header_word;
        if (word_index == 5'd9) captured_destination[15:0]  <= header_word;
        if (sum_en) running_sum <= running_sum + {5'b0, add_val};
        if (word_index != 5'd31) word_index <= word_index + 5'd1;
      end else if (cmd.emit) begin
        running_sum          <= '0;
        word_index           <= '0;
        captured_destination <= '0;
        captured_ttl         <= '0;
        captured_ihl         <= '0;
      end
      rd_valid <= cmd.walk_step;
      if (cmd.walk_init) begin
        walk_index <= '0;
        best_len   <= '0;
        found      <= 1'b0;
      end else begin
        if (cmd.walk_step) walk_index <= walk_index + 1'b1;
        if (hit) begin
          best_len <= rd_entry.len;
          found    <= 1'b1;
        end
      end
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.add_route && (route_count < DEPTH_CNT)) begin
      route_table[route_count[IDX_W-1:0]] <= '{
        prefix: route_prefix & prefix_mask(len_clamped),
        len:    len_clamped,
        hop:    route_next_hop
      };
    end
    if (cmd.walk_step) begin
      rd_entry <= route_table[walk_index[IDX_W-1:0]];
    end
  end

  // best hop and result beat
  always_ff @(posedge clk) begin
    if (hit) begin
      best_hop <= rd_entry.hop;
    end
    if (cmd.emit) begin
      verdict      <= verdict_next;
      next_hop     <= (verdict_next == VERDICT_FORWARD) ? best_hop : 32'd0;
      new_checksum <= (verdict_next == VERDICT_FORWARD) ? csum : 16'd0;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    route_count <= DEPTH_CNT)
    else $error("route count beyond table depth");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (walk_index <= route_count))
    else $error("walk index passed route count");
  a_found_has_len: assert property (@(posedge clk) disable iff (rst)
    found |-> (best_len != '0))
    else $error("match recorded with zero prefix length");
`endif

endmodule

[rtl/ipv4_lpm_ctrl.sv]
// Controller state machine: decodes accepted beats, sequences the table walk
// and raises the result strobe. Depends on ipv4_lpm_pkg; drives ipv4_lpm_dp.
module ipv4_lpm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             operation,
  input  logic                   header_last,
  output ipv4_lpm_pkg::cmd_t     cmd,
  input  ipv4_lpm_pkg::status_t  status,
  output logic                   done
);
  import ipv4_lpm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_WALK,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.clear_table = (operation == OP_CLEAR);
          cmd.add_route   = (operation == OP_ADD);
          cmd.take_word   = (operation == OP_HEADER);
          if ((operation == OP_HEADER) && header_last) begin
            state_next = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        cmd.walk_init = 1'b1;
        state_next = (status.is_local || status.ttl_zero) ? S_EMIT : S_WALK;
      end
      S_WALK: begin
        if (status.walk_end) begin
          state_next = S_EMIT;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EMIT);
    end
  end

`ifndef SYNTH
  a_last_to_decide: assert property (@(posedge clk) disable iff (rst)
    (accept && (operation == OP_HEADER) && header_last) |=> (state == S_DECIDE))
    else $error("final header beat did not start a decision");
  a_done_after_emit: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_EMIT) && (state == S_IDLE))
    else $error("result strobe without an emit cycle");
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_table, cmd.add_route, cmd.take_word,
              cmd.walk_init, cmd.walk_step, cmd.emit}))
    else $error("more than one datapath command");
  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_step |-> !status.walk_end)
    else $error("table read past route count");
`endif

endmodule

[rtl/ipv4_forward_lpm_unit.sv]
// Clear, add-route and non-final header beats never raise busy. A final header beat raises
// busy through the decide and emit states (local or TTL error) or through decide, walk and
// emit (lookup, one table entry per cycle through the registered table read port); done
// pulses for one cycle as busy falls. Throughput: one beat a cycle while busy is low.
// Reset (rst, synchronous): empties the table, clears header state and local_address;
// table contents are not cleared. The receiver cannot stall: the result is shown once.
module ipv4_forward_lpm_unit #(
  parameter int unsigned TABLE_DEPTH = ipv4_lpm_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [31:0] route_prefix,
  input  logic [5:0]  route_prefix_length,
  input  logic [31:0] route_next_hop,
  input  logic [15:0] header_word,
  input  logic        header_last,
  input  logic        local_address_we,
  input  logic [31:0] local_address,
  output logic        done,
  output logic [1:0]  verdict,
  output logic [31:0] next_hop,
  output logic [15:0] new_checksum
);
  import ipv4_lpm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing
  ipv4_lpm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .header_last (header_last),
    .cmd         (cmd),
    .status      (status),
    .done        (done)
  );

  // table, header capture and result
  ipv4_lpm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .route_prefix        (route_prefix),
    .route_prefix_length (route_prefix_length),
    .route_next_hop      (route_next_hop),
    .header_word         (header_word),
    .local_address_we    (local_address_we),
    .local_address       (local_address),
    .verdict             (verdict),
    .next_hop            (next_hop),
    .new_checksum        (new_checksum)
  );

endmodule

[sim/tb.sv]
// Self-checking bench for ipv4_forward_lpm_unit: directed table first, then random traffic.
// Each result is compared with a predicted verdict, next hop and checksum.
// Depends on ipv4_lpm_pkg (op codes, verdicts, table depth) and the unit under test.
module tb;
  import ipv4_lpm_pkg::*;

  localparam int ROUTE_SLOTS = TABLE_DEPTH_DEF;
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int BEATS_PER_PHASE = 225;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] prefix;
    logic [5:0]  plen;
    logic [31:0] hop;
    logic [15:0] word;
    logic        last;
  } beat_t;

  typedef struct {
    verdict_t    verdict;
    logic [31:0] hop;
    logic [15:0] csum;
  } fwd_result_t;

  typedef enum {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    beat_t       b;
    bit          typed;
    fwd_result_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  operation;
  logic [31:0] route_prefix;
  logic [5:0]  route_prefix_length;
  logic [31:0] route_next_hop;
  logic [15:0] header_word;
  logic        header_last;
  logic        local_address_we;
  logic [31:0] local_address;
  logic        done;
  logic [1:0]  verdict;
  logic [31:0] next_hop;
  logic [15:0] new_checksum;

  // predictor state: route table, header capture, local address
  logic [31:0] tbl_prefix [ROUTE_SLOTS];
  logic [5:0]  tbl_len    [ROUTE_SLOTS];
  logic [31:0] tbl_hop    [ROUTE_SLOTS];
  int          n_routes = 0;
  logic [31:0] hdr_sum = '0;
  int          hdr_idx = 0;
  int          hdr_ihl = 0;
  logic [7:0]  hdr_ttl = '0;
  logic [31:0] hdr_dst = '0;
  logic [31:0] my_addr = '0;

  fwd_result_t verdict_q [$];
  dir_row_t    dir_rows [$];
  fwd_result_t no_typed;
  int          mismatch_count = 0;
  int          beats_sent = 0;
  int          cycle_count = 0;
  bit          idling = 1'b0;

  ipv4_forward_lpm_unit #(.TABLE_DEPTH(ROUTE_SLOTS)) DUT (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .operation           (operation),
    .route_prefix        (route_prefix),
    .route_prefix_length (route_prefix_length),
    .route_next_hop      (route_next_hop),
    .header_word         (header_word),
    .header_last         (header_last),
    .local_address_we    (local_address_we),
    .local_address       (local_address),
    .done                (done),
    .verdict             (verdict),
    .next_hop            (next_hop),
    .new_checksum        (new_checksum)
  );

  always #10 clk = ~clk;

  // network mask; lengths above 32 count as 32
  function automatic logic [31:0] net_mask(input logic [5:0] len);
    if (len == 6'd0) return 32'h0;
    if (len > 6'd32) len = 6'd32;
    return 32'hFFFF_FFFF << (32 - int'(len));
  endfunction

  // advance the predicted state by one beat; returns 1 when a result is due
  function automatic bit forward_decision(input beat_t b, output fwd_result_t r);
    logic [31:0] add;
    logic [31:0] s;
    logic [5:0]  len;
    logic [5:0]  best;
    bit          hit;
    int          i;
    r.verdict = VERDICT_LOCAL;
    r.hop = '0;
    r.csum = '0;
    case (b.op)
      OP_CLEAR: begin
        n_routes = 0;
        return 1'b0;
      end
      OP_ADD: begin
        if (n_routes < ROUTE_SLOTS) begin
          len = (b.plen > 6'd32) ? 6'd32 : b.plen;
          tbl_len[n_routes] = len;
          tbl_prefix[n_routes] = b.prefix & net_mask(len);
          tbl_hop[n_routes] = b.hop;
          n_routes++;
        end
        return 1'b0;
      end
      OP_HEADER: ;
      default: return 1'b0;
    endcase

    // header capture and running sum
    if (hdr_idx == 0) hdr_ihl = int'(b.word[11:8]);
    if (hdr_idx == 4) hdr_ttl = b.word[15:8];
    if (hdr_idx == 8) hdr_dst[31:16] = b.word;
    if (hdr_idx == 9) hdr_dst[15:0] = b.word;
    if (hdr_idx < 2 * hdr_ihl && hdr_idx != 5) begin
      add = {16'h0, b.word};
      if (hdr_idx == 4 && add >= 32'h100) add -= 32'h100;
      hdr_sum += add;
    end
    if (hdr_idx < 31) hdr_idx++;
    if (!b.last) return 1'b0;

    // verdict on the final word
    if (hdr_dst == my_addr) begin
      r.verdict = VERDICT_LOCAL;
    end else if (hdr_ttl == 8'd0) begin
      r.verdict = VERDICT_TTL_ERROR;
    end else begin
      best = '0;
      hit = 1'b0;
      for (i = 0; i < n_routes; i++) begin
        if (tbl_len[i] > best && (hdr_dst & net_mask(tbl_len[i])) == tbl_prefix[i]) begin
          best = tbl_len[i];
          r.hop = tbl_hop[i];
          hit = 1'b1;
        end
      end
      if (hit) begin
        r.verdict = VERDICT_FORWARD;
        s = hdr_sum;
        s = (s & 32'hFFFF) + (s >> 16);
        s = (s & 32'hFFFF) + (s >> 16);
        r.csum = ~s[15:0];
      end else begin
        r.verdict = VERDICT_NO_ROUTE;
        r.hop = '0;
      end
    end
    hdr_sum = '0;
    hdr_idx = 0;
    hdr_ihl = 0;
    hdr_ttl = '0;
    hdr_dst = '0;
    return 1'b1;
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    b.op = 2'($urandom_range(0, 3));
    b.prefix = $urandom;
    b.plen = 6'($urandom_range(0, 63));
    b.hop = $urandom;
    b.word = 16'($urandom_range(0, 65535));
    b.last = 1'($urandom_range(0, 1));
    return b;
  endfunction

  function automatic void dir_row(input row_kind_t k, input logic [1:0] op,
                                  input logic [31:0] pfx, input logic [5:0] plen,
                                  input logic [31:0] hop, input logic [15:0] w,
                                  input logic last, input bit typed, input verdict_t v,
                                  input logic [31:0] ehop, input logic [15:0] ecs);
    dir_row_t row;
    row.kind = k;
    row.b.op = op;
    row.b.prefix = pfx;
    row.b.plen = plen;
    row.b.hop = hop;
    row.b.word = w;
    row.b.last = last;
    row.typed = typed;
    row.res.verdict = v;
    row.res.hop = ehop;
    row.res.csum = ecs;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // present one beat, optionally after an idle burst, and wait for acceptance
  task automatic send_beat(input beat_t b, input bit typed, input fwd_result_t res);
    fwd_result_t r;
    beat_t       noise;
    if (idling && $urandom_range(0, 99) < 15) begin
      noise = random_beat();
      start <= 1'b0;
      operation <= noise.op;
      header_word <= noise.word;
      header_last <= noise.last;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start <= 1'b1;
    operation <= b.op;
    route_prefix <= b.prefix;
    route_prefix_length <= b.plen;
    route_next_hop <= b.hop;
    header_word <= b.word;
    header_last <= b.last;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
    if (forward_decision(b, r)) begin
      if (typed) r = res;
      verdict_q.insert(verdict_q.size(), r);
    end
  endtask

  task automatic send_op(input logic [1:0] op);
    beat_t b;
    b = random_beat();
    b.op = op;
    send_beat(b, 1'b0, no_typed);
  endtask

  // add a route; half of them share the top bits of an existing entry
  task automatic send_route();
    beat_t b;
    int    r;
    int    i;
    b = random_beat();
    b.op = OP_ADD;
    r = $urandom_range(0, 99);
    if (r < 8) b.plen = 6'd0;
    else if (r < 16) b.plen = 6'($urandom_range(33, 63));
    else b.plen = 6'($urandom_range(1, 32));
    if (n_routes > 0 && $urandom_range(0, 1) == 1) begin
      i = $urandom_range(0, n_routes - 1);
      b.prefix = tbl_prefix[i] | (b.prefix & ~net_mask(tbl_len[i]));
    end
    send_beat(b, 1'b0, no_typed);
  endtask

  // one header: mostly well formed, some short or over-long
  task automatic send_header();
    logic [15:0] w [40];
    logic [3:0]  ihl;
    logic [31:0] dst;
    logic [7:0]  ttl;
    beat_t       b;
    int          nw;
    int          base;
    int          i;
    int          r;
    ihl = ($urandom_range(0, 99) < 80) ? 4'd5 : 4'($urandom_range(0, 15));
    base = (2 * int'(ihl) > 10) ? 2 * int'(ihl) : 10;
    r = $urandom_range(0, 99);
    if (r < 70) nw = base;
    else if (r < 85) nw = $urandom_range(1, 9);
    else nw = $urandom_range(base, 40);

    r = $urandom_range(0, 99);
    if (r < 55 && n_routes > 0) begin
      i = $urandom_range(0, n_routes - 1);
      dst = tbl_prefix[i] | ($urandom & ~net_mask(tbl_len[i]));
    end else if (r < 70) begin
      dst = my_addr;
    end else begin
      dst = $urandom;
    end
    r = $urandom_range(0, 99);
    if (r < 10) ttl = 8'h00;
    else if (r < 15) ttl = 8'h01;
    else if (r < 20) ttl = 8'hFF;
    else ttl = 8'($urandom_range(0, 255));

    for (i = 0; i < 40; i++) w[i] = 16'($urandom_range(0, 65535));
    w[0][11:8] = ihl;
    w[4][15:8] = ttl;
    w[8] = dst[31:16];
    w[9] = dst[15:0];

    for (i = 0; i < nw; i++) begin
      // table traffic in the middle of a header must not disturb it
      if ($urandom_range(0, 99) < 3) begin
        r = $urandom_range(0, 2);
        if (r == 0) send_op(OP_CLEAR);
        else if (r == 1) send_route();
        else send_op(OP_RESERVED);
      end
      b = random_beat();
      b.op = OP_HEADER;
      b.word = w[i];
      b.last = (i == nw - 1);
      send_beat(b, 1'b0, no_typed);
    end
  endtask

  // hold off until every predicted result has been seen
  task automatic drain();
    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_local(input logic [31:0] addr);
    drain();
    local_address_we <= 1'b1;
    local_address <= addr;
    @(posedge clk);
    local_address_we <= 1'b0;
    my_addr = addr;
  endtask

  // result checker
  always @(posedge clk) begin
    fwd_result_t e;
    if (!rst && done) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result with none expected: verdict %0d hop %h csum %h",
                 $time, verdict, next_hop, new_checksum);
        mismatch_count++;
      end else begin
        e = verdict_q.pop_front();
        if (verdict !== e.verdict || next_hop !== e.hop || new_checksum !== e.csum) begin
          $display("%0t: expected verdict %0d hop %h csum %h, got verdict %0d hop %h csum %h",
                   $time, e.verdict, e.hop, e.csum, verdict, next_hop, new_checksum);
          mismatch_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int          p;
    int          r;
    int          goal;
    logic [31:0] addr;
    bit          held;
    rst <= 1'b1;
    start <= 1'b0;
    operation <= OP_CLEAR;
    route_prefix <= '0;
    route_prefix_length <= '0;
    route_next_hop <= '0;
    header_word <= '0;
    header_last <= 1'b0;
    local_address_we <= 1'b0;
    local_address <= '0;
    held = 1'b0;
    no_typed.verdict = VERDICT_LOCAL;
    no_typed.hop = '0;
    no_typed.csum = '0;

    // directed rows; cfg rows carry the address in the prefix column
    // after reset, destination 0 equals local address 0
    dir_row(ROW_BEAT, OP_HEADER, 32'h0, 6'd0, 32'h0, 16'h0000, 1'b1,
            1'b1, VERDICT_LOCAL, 32'h0, 16'h0);
    // reserved op with all fields at their top values: ignored
    dir_row(ROW_BEAT, OP_RESERVED, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    dir_row(ROW_CFG, OP_CLEAR, 32'hFFFF_FFFF, 6'd0, 32'h0, 16'h0, 1'b0,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    // one-word header: TTL never arrives, so zero
    dir_row(ROW_BEAT, OP_HEADER, 32'h0, 6'd0, 32'h0, 16'h4500, 1'b1,
            1'b1, VERDICT_TTL_ERROR, 32'h0, 16'h0);
    // length over 32, equal lengths, unmasked prefix bits, zero length
    dir_row(ROW_BEAT, OP_ADD, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 16'h0, 1'b0,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    dir_row(ROW_BEAT, OP_ADD, 32'h0A00_0000, 6'd8, 32'h0101_0101, 16'h0, 1'b0,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    dir_row(ROW_BEAT, OP_ADD, 32'h0A0B_FFFF, 6'd16, 32'h0202_0202, 16'h0, 1'b0,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    dir_row(ROW_BEAT, OP_ADD, 32'h0A0B_0000, 6'd16, 32'h0303_0303, 16'h0, 1'b0,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    dir_row(ROW_BEAT, OP_ADD, 32'h0000_0000, 6'd0, 32'h0404_0404, 16'h0, 1'b0,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    // full 20-byte header to 10.11.12.13, checked by the predictor
    dir_row(ROW_BEAT, OP_HEADER, 32'h0, 6'd0, 32'h0, 16'h4500, 1'b0,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    dir_row(ROW_BEAT, OP_HEADER, 32'h0, 6'd0, 32'h0, 16'h0054, 1'b0,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    dir_row(ROW_BEAT, OP_HEADER, 32'h0, 6'd0, 32'h0, 16'h1C46, 1'b0,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    dir_row(ROW_BEAT, OP_HEADER, 32'h0, 6'd0, 32'h0, 16'h4000, 1'b0,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    dir_row(ROW_BEAT, OP_HEADER, 32'h0, 6'd0, 32'h0, 16'h4011, 1'b0,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    dir_row(ROW_BEAT, OP_HEADER, 32'h0, 6'd0, 32'h0, 16'hB1E6, 1'b0,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    dir_row(ROW_BEAT, OP_HEADER, 32'h0, 6'd0, 32'h0, 16'hC0A8, 1'b0,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    dir_row(ROW_BEAT, OP_HEADER, 32'h0, 6'd0, 32'h0, 16'h0001, 1'b0,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    dir_row(ROW_BEAT, OP_HEADER, 32'h0, 6'd0, 32'h0, 16'h0A0B, 1'b0,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    dir_row(ROW_BEAT, OP_HEADER, 32'h0, 6'd0, 32'h0, 16'h0C0D, 1'b1,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    dir_row(ROW_BEAT, OP_CLEAR, 32'h0, 6'd0, 32'h0, 16'h0, 1'b0,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    // empty table, TTL 1, destination 0: no route
    dir_row(ROW_BEAT, OP_HEADER, 32'h0, 6'd0, 32'h0, 16'h4500, 1'b0,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    dir_row(ROW_BEAT, OP_HEADER, 32'h0, 6'd0, 32'h0, 16'h0000, 1'b0,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    dir_row(ROW_BEAT, OP_HEADER, 32'h0, 6'd0, 32'h0, 16'h0000, 1'b0,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    dir_row(ROW_BEAT, OP_HEADER, 32'h0, 6'd0, 32'h0, 16'h0000, 1'b0,
            1'b0, VERDICT_LOCAL, 32'h0, 16'h0);
    dir_row(ROW_BEAT, OP_HEADER, 32'h0, 6'd0, 32'h0, 16'h0100, 1'b1,
            1'b1, VERDICT_NO_ROUTE, 32'h0, 16'h0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) set_local(dir_rows[i].b.prefix);
      else send_beat(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].res);
    end

    // random phases, each under its own local address; the last one without idling
    goal = beats_sent;
    for (p = 0; p < 4; p++) begin
      idling = (p != 3);
      goal += BEATS_PER_PHASE;
      case (p)
        0: addr = 32'h0;
        1: addr = 32'hFFFF_FFFF;
        2: addr = $urandom;
        default: begin
          addr = $urandom;
          if (n_routes > 0) addr = tbl_prefix[0] | (addr & ~net_mask(tbl_len[0]));
        end
      endcase
      set_local(addr);
      if ($urandom_range(0, 1) == 1) send_op(OP_CLEAR);
      repeat ($urandom_range(4, 20)) send_route();
      while (beats_sent < goal) begin
        if (p == 1 && !held && beats_sent > goal - 120) begin
          held = 1'b1;
          drain();
        end
        r = $urandom_range(0, 199);
        if (r < 3) send_op(OP_CLEAR);
        else if (r < 43) send_route();
        else if (r < 48) send_op(OP_RESERVED);
        else send_header();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && verdict_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
